// ===== hdl/pusr_pkg.sv =====
// Shared types and constants for the picture unit scroll register file.
// Used by pusr_exec, the top level and the testbench files; depends on nothing else.
`default_nettype none

package pusr_pkg;

   localparam int REG_COUNT_DEF = 8;
   localparam int SEL_W         = 3;
   localparam int LOOPY_W       = 15;

   // Item kinds.
   localparam logic [2:0] MODE_READ   = 3'd0;
   localparam logic [2:0] MODE_WRITE  = 3'd1;
   localparam logic [2:0] MODE_HXFER  = 3'd2;
   localparam logic [2:0] MODE_VXFER  = 3'd3;
   localparam logic [2:0] MODE_INCR   = 3'd4;
   localparam logic [2:0] MODE_STATUS = 3'd5;

   // Register indexes with side effects.
   localparam logic [SEL_W-1:0] IDX_CTRL   = 3'd0;
   localparam logic [SEL_W-1:0] IDX_STATUS = 3'd2;
   localparam logic [SEL_W-1:0] IDX_SCROLL = 3'd5;
   localparam logic [SEL_W-1:0] IDX_ADDR   = 3'd6;

   localparam logic [LOOPY_W-1:0] HXFER_MASK = 15'h041F;
   localparam logic [LOOPY_W-1:0] VXFER_MASK = 15'h7BE0;

   typedef struct packed {
      logic [2:0]       mode;
      logic [SEL_W-1:0] sel;
      logic [7:0]       data;
      logic [2:0]       flags;
      logic [7:0]       buf_val;
   } item_type;

   typedef struct packed {
      logic             en;
      logic [SEL_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic [LOOPY_W-1:0] vram_address;
      logic [8:0]         scroll_x;
      logic [8:0]         scroll_y;
      logic               toggle_state;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/picture_unit_scroll_register_file_top.sv =====
// Picture unit scroll register file, top level.
// An accepted word waits in the read stage while its register byte is read, then enters
// the output register when the execute stage advances; a full output register can hold
// it off. Throughput: one word per cycle while results are taken, set by the single
// read and single write port of the register byte RAM. Reset: synchronous, active high;
// all register bytes read as zero; loopy registers, fine X, toggle, read buffer cleared.
`default_nettype none

module picture_unit_scroll_register_file_top
   import pusr_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_mode,
   input  wire logic [SEL_W-1:0]   req_reg_select,
   input  wire logic [7:0]         req_write_data,
   input  wire logic [2:0]         req_status_flags,
   input  wire logic [7:0]         req_buffer_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_read_data,
   output logic [LOOPY_W-1:0]      rsp_vram_address,
   output logic [8:0]              rsp_scroll_x,
   output logic [8:0]              rsp_scroll_y,
   output logic                    rsp_toggle_state
);

   localparam int ADDR_W = $clog2(REG_COUNT);

   // Read stage: the accepted word waits here while its register byte is read.
   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff;
   logic              s1_vld_ff;      // entry had been written before the read
   logic              s1_fwd_ff;      // entry was written at the very edge of the read
   logic [7:0]        s1_fwd_data_ff;

   logic [REG_COUNT-1:0] written_ff, written_in;

   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;

   logic              accept;
   logic              advance;
   logic [SEL_W-1:0]  rd_sel;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_we;
   logic [7:0]        ram_q;
   logic [7:0]        stored;
   logic              same_entry;
   wr_type            wr;
   result_type        result;
   item_type          req_item;

   // The execute stage moves on whenever the output register is free or drains
   // this cycle; a new word is taken whenever the read stage empties.
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign req_item.mode    = req_mode;
   assign req_item.sel     = req_reg_select;
   assign req_item.data    = req_write_data;
   assign req_item.flags   = req_status_flags;
   assign req_item.buf_val = req_buffer_value;

   // Increment looks at the control byte, status update at the status byte;
   // everything else reads the selected register.
   always_comb begin
      case (req_mode)
         MODE_INCR:   rd_sel = IDX_CTRL;
         MODE_STATUS: rd_sel = IDX_STATUS;
         default:     rd_sel = req_reg_select;
      endcase
   end

   assign ram_raddr  = ADDR_W'(rd_sel);
   assign ram_waddr  = ADDR_W'(wr.addr);
   assign ram_we     = wr.en && advance;
   // A write landing at the same edge as the read is forwarded, since the RAM
   // returns the old contents in that case.
   assign same_entry = ram_we && (ram_waddr == ram_raddr);

   pusr_ram #(
      .WIDTH (8),
      .DEPTH (REG_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // Entries never written read as zero, which matches the all-zero reset.
   assign stored = s1_fwd_ff ? s1_fwd_data_ff : (s1_vld_ff ? ram_q : 8'd0);

   pusr_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (s1_item_ff),
      .stored  (stored),
      .wr      (wr),
      .result  (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      written_in = written_ff;
      if (ram_we) begin
         written_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         written_ff   <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff     <= req_item;
         s1_vld_ff      <= written_ff[ram_raddr];
         s1_fwd_ff      <= same_entry;
         s1_fwd_data_ff <= wr.data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_ff.read_data;
   assign rsp_vram_address = out_ff.vram_address;
   assign rsp_scroll_x     = out_ff.scroll_x;
   assign rsp_scroll_y     = out_ff.scroll_y;
   assign rsp_toggle_state = out_ff.toggle_state;

endmodule

`default_nettype wire

// ===== hdl/pusr_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Self-contained; no package needed.
`default_nettype none

module pusr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pusr_exec.sv =====
// Execute stage: holds the loopy registers, fine X, toggle and read buffer,
// and forms the register byte write-back and the result. Uses pusr_pkg.
`default_nettype none

module pusr_exec
   import pusr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire item_type   item,
   input  wire logic [7:0] stored,
   output wr_type          wr,
   output result_type      result
);

   logic [LOOPY_W-1:0] temp_ff, temp_in;
   logic [LOOPY_W-1:0] active_ff, active_in;
   logic [2:0]         fine_x_ff, fine_x_in;
   logic               toggle_ff, toggle_in;
   logic [7:0]         rbuf_ff, rbuf_in;

   always_comb begin
      logic [7:0] rd;
      logic [LOOPY_W-1:0] step;
      temp_in   = temp_ff;
      active_in = active_ff;
      fine_x_in = fine_x_ff;
      toggle_in = toggle_ff;
      rbuf_in   = rbuf_ff;
      rd        = 8'd0;
      wr.en     = 1'b0;
      wr.addr   = item.sel;
      wr.data   = item.data;
      step      = stored[2] ? LOOPY_W'(32) : LOOPY_W'(1);
      case (item.mode)
         MODE_READ: begin
            if (item.sel == IDX_STATUS) begin
               rd        = {stored[7:5], rbuf_ff[4:0]};
               wr.en     = 1'b1;
               wr.data   = {1'b0, stored[6:0]};
               toggle_in = 1'b0;
            end else begin
               rd = stored;
            end
         end
         MODE_WRITE: begin
            wr.en = 1'b1;
            if (item.sel == IDX_CTRL) begin
               temp_in = {temp_ff[14:12], item.data[1:0], temp_ff[9:0]};
            end else if (item.sel == IDX_SCROLL) begin
               if (!toggle_ff) begin
                  temp_in   = {temp_ff[14:5], item.data[7:3]};
                  fine_x_in = item.data[2:0];
               end else begin
                  temp_in = {item.data[2:0], temp_ff[11:10], item.data[7:3], temp_ff[4:0]};
               end
               toggle_in = ~toggle_ff;
            end else if (item.sel == IDX_ADDR) begin
               if (!toggle_ff) begin
                  // The first address write also clears the top bit.
                  temp_in = {1'b0, item.data[5:0], temp_ff[7:0]};
               end else begin
                  temp_in   = {temp_ff[14:8], item.data};
                  active_in = {temp_ff[14:8], item.data};
               end
               toggle_in = ~toggle_ff;
            end
         end
         MODE_HXFER: begin
            active_in = (active_ff & ~HXFER_MASK) | (temp_ff & HXFER_MASK);
         end
         MODE_VXFER: begin
            active_in = (active_ff & ~VXFER_MASK) | (temp_ff & VXFER_MASK);
         end
         MODE_INCR: begin
            active_in = active_ff + step;
         end
         MODE_STATUS: begin
            wr.en   = 1'b1;
            wr.addr = IDX_STATUS;
            wr.data = {item.flags, stored[4:0]};
            rbuf_in = item.buf_val;
         end
         default: begin
         end
      endcase
      result.read_data    = rd;
      result.vram_address = active_in;
      result.scroll_x     = {active_in[10], active_in[4:0], fine_x_in};
      result.scroll_y     = {active_in[11], active_in[9:5], active_in[14:12]};
      result.toggle_state = toggle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff   <= '0;
         active_ff <= '0;
         fine_x_ff <= '0;
         toggle_ff <= 1'b0;
         rbuf_ff   <= '0;
      end else if (step_en) begin
         temp_ff   <= temp_in;
         active_ff <= active_in;
         fine_x_ff <= fine_x_in;
         toggle_ff <= toggle_in;
         rbuf_ff   <= rbuf_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/scroll_regs_checker.sv =====
// Checker for the picture unit scroll register file: predicts one result word per
// accepted request word and compares it with what the block returns.
// Depends on pusr_pkg for the word layouts, mode codes and register indexes.
`timescale 1ns / 100ps

module scroll_regs_checker
   import pusr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [SEL_W-1:0]   req_reg_select,
   input  logic [7:0]         req_write_data,
   input  logic [2:0]         req_status_flags,
   input  logic [7:0]         req_buffer_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_read_data,
   input  logic [LOOPY_W-1:0] rsp_vram_address,
   input  logic [8:0]         rsp_scroll_x,
   input  logic [8:0]         rsp_scroll_y,
   input  logic               rsp_toggle_state,
   output int                 fail_count,
   output int                 pending
);

   logic [7:0]         regs_q [REG_COUNT_DEF];
   logic [LOOPY_W-1:0] tmp_addr;
   logic [LOOPY_W-1:0] cur_addr;
   logic [2:0]         fine_x_q;
   logic               toggle_q;
   logic [7:0]         rd_buf_q;

   result_type expected_results[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Applies one request word to the shadow registers and returns its result word.
   function automatic result_type step_scroll_regs(item_type w);
      result_type r;
      r = '0;
      case (w.mode)
         MODE_READ: begin
            if (w.sel == IDX_STATUS) begin
               r.read_data = {regs_q[IDX_STATUS][7:5], rd_buf_q[4:0]};
               regs_q[IDX_STATUS][7] = 1'b0;
               toggle_q = 1'b0;
            end else begin
               r.read_data = regs_q[w.sel];
            end
         end
         MODE_WRITE: begin
            case (w.sel)
               IDX_CTRL: tmp_addr[11:10] = w.data[1:0];
               IDX_SCROLL: begin
                  if (!toggle_q) begin
                     tmp_addr[4:0] = w.data[7:3];
                     fine_x_q      = w.data[2:0];
                  end else begin
                     tmp_addr[9:5]   = w.data[7:3];
                     tmp_addr[14:12] = w.data[2:0];
                  end
                  toggle_q = ~toggle_q;
               end
               IDX_ADDR: begin
                  // The high write also clears bit 14.
                  if (!toggle_q) begin
                     tmp_addr[13:8] = w.data[5:0];
                     tmp_addr[14]   = 1'b0;
                  end else begin
                     tmp_addr[7:0] = w.data;
                     cur_addr      = tmp_addr;
                  end
                  toggle_q = ~toggle_q;
               end
               default: ;
            endcase
            regs_q[w.sel] = w.data;
         end
         MODE_HXFER: cur_addr = (cur_addr & ~HXFER_MASK) | (tmp_addr & HXFER_MASK);
         MODE_VXFER: cur_addr = (cur_addr & ~VXFER_MASK) | (tmp_addr & VXFER_MASK);
         MODE_INCR:  cur_addr = cur_addr + (regs_q[IDX_CTRL][2] ? 15'd32 : 15'd1);
         MODE_STATUS: begin
            regs_q[IDX_STATUS][7:5] = w.flags;
            rd_buf_q = w.buf_val;
         end
         default: ;
      endcase
      r.vram_address = cur_addr;
      r.scroll_x     = {cur_addr[10], cur_addr[4:0], fine_x_q};
      r.scroll_y     = {cur_addr[11], cur_addr[9:5], cur_addr[14:12]};
      r.toggle_state = toggle_q;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      item_type   w;
      result_type want;
      if (reset) begin
         foreach (regs_q[i]) regs_q[i] = 8'h00;
         tmp_addr = '0;
         cur_addr = '0;
         fine_x_q = '0;
         toggle_q = 1'b0;
         rd_buf_q = 8'h00;
         expected_results.delete();
      end else begin
         // Compare before predicting, so a word cannot be matched against its own request.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result word with nothing expected, got address 0x%0h",
                        $time, rsp_vram_address);
               fail_count = fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", 32'(want.read_data), 32'(rsp_read_data));
               check_field("vram_address", 32'(want.vram_address),
                           32'(rsp_vram_address));
               check_field("scroll_x", 32'(want.scroll_x), 32'(rsp_scroll_x));
               check_field("scroll_y", 32'(want.scroll_y), 32'(rsp_scroll_y));
               check_field("toggle_state", 32'(want.toggle_state),
                           32'(rsp_toggle_state));
            end
         end
         if (req_valid && req_ready) begin
            w.mode    = req_mode;
            w.sel     = req_reg_select;
            w.data    = req_write_data;
            w.flags   = req_status_flags;
            w.buf_val = req_buffer_value;
            expected_results.push_back(step_scroll_regs(w));
         end
      end
      pending <= expected_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the scroll register file testbench: clock, reset, request words and
// result back-pressure, plus the verdict. Depends on pusr_pkg, the block's top
// level and scroll_regs_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module testbench
   import pusr_pkg::*;
();

   // Mode codes the block ignores; they still return one result word.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   // Plain storage registers without side effects.
   localparam logic [SEL_W-1:0] IDX_SPARE_1 = 3'd1;
   localparam logic [SEL_W-1:0] IDX_SPARE_7 = 3'd7;

   // Cycles allowed at the end, after the last drain, to catch any stray result word.
   localparam int SETTLE_CYCLES = 8;
   // Cycles without any accepted word before the run is declared hung. Idle
   // stretches are random per cycle, so this sits far above any plausible stall.
   localparam int STALL_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 175;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_mode = '0;
   logic [SEL_W-1:0]   req_reg_select = '0;
   logic [7:0]         req_write_data = '0;
   logic [2:0]         req_status_flags = '0;
   logic [7:0]         req_buffer_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_read_data;
   logic [LOOPY_W-1:0] rsp_vram_address;
   logic [8:0]         rsp_scroll_x;
   logic [8:0]         rsp_scroll_y;
   logic               rsp_toggle_state;

   int fail_count;
   int pending;
   int stall_cycles = 0;
   // Chance, in percent, that the sender or the receiver idles in a given cycle.
   int send_idle_pct = 12;
   int take_idle_pct = 56;

   initial begin
      forever #5 clock = ~clock;
   end

   picture_unit_scroll_register_file_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_reg_select   (req_reg_select),
      .req_write_data   (req_write_data),
      .req_status_flags (req_status_flags),
      .req_buffer_value (req_buffer_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_vram_address (rsp_vram_address),
      .rsp_scroll_x     (rsp_scroll_x),
      .rsp_scroll_y     (rsp_scroll_y),
      .rsp_toggle_state (rsp_toggle_state)
   );

   scroll_regs_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_reg_select   (req_reg_select),
      .req_write_data   (req_write_data),
      .req_status_flags (req_status_flags),
      .req_buffer_value (req_buffer_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_vram_address (rsp_vram_address),
      .rsp_scroll_x     (rsp_scroll_x),
      .rsp_scroll_y     (rsp_scroll_y),
      .rsp_toggle_state (rsp_toggle_state),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // The receiver decides afresh every cycle whether it takes a result word.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // Watchdog: any accepted word on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Presents one request word and holds it until the block takes it. The task
   // returns at the accepting edge, so a following call keeps valid high without
   // a gap; a random idle stretch lowers valid here instead.
   task automatic send_word(input logic [2:0] mode, input logic [SEL_W-1:0] sel,
                            input logic [7:0] data, input logic [2:0] flags,
                            input logic [7:0] bufv);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_reg_select   <= sel;
      req_write_data   <= data;
      req_status_flags <= flags;
      req_buffer_value <= bufv;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Random word. Writes lean toward the scroll and address registers so the
   // shared toggle is exercised hard, and status reads break up the pairs. All
   // payload fields are random in every mode, so every input bit moves.
   task automatic send_random_word();
      int               pick;
      int               reg_pick;
      logic [2:0]       mode;
      logic [SEL_W-1:0] sel;
      pick     = $urandom_range(99);
      reg_pick = $urandom_range(9);
      sel      = SEL_W'($urandom_range(REG_COUNT_DEF - 1));
      if (pick < 18) begin
         mode = MODE_READ;
         if (reg_pick < 4) sel = IDX_STATUS;
      end else if (pick < 55) begin
         mode = MODE_WRITE;
         if (reg_pick < 3)      sel = IDX_SCROLL;
         else if (reg_pick < 6) sel = IDX_ADDR;
         else if (reg_pick < 7) sel = IDX_CTRL;
      end else if (pick < 63) begin
         mode = MODE_HXFER;
      end else if (pick < 71) begin
         mode = MODE_VXFER;
      end else if (pick < 82) begin
         mode = MODE_INCR;
      end else if (pick < 94) begin
         mode = MODE_STATUS;
      end else begin
         mode = $urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A;
      end
      send_word(mode, sel, 8'($urandom_range(255)), 3'($urandom_range(7)),
                8'($urandom_range(255)));
   endtask

   // Holds the sender off until every predicted result word has come back. The
   // first wait lets the checker count a word accepted at this very edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int phase;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A status read right after reset sees zeros.
      send_word(MODE_READ, IDX_STATUS, 8'h00, 3'd0, 8'h00);
      // Load the temporary register with all ones: both nametable bits from the
      // control register, then a full scroll pair. Control bit 2 selects +32.
      send_word(MODE_WRITE, IDX_CTRL, 8'hFF, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_SCROLL, 8'hFF, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_SCROLL, 8'hFF, 3'd0, 8'h00);
      // Horizontal and vertical transfers fill the active register, and the
      // increment by 32 from the top address wraps within 15 bits.
      send_word(MODE_HXFER, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      send_word(MODE_VXFER, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      send_word(MODE_INCR, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      send_word(MODE_INCR, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      // A high address write clears bit 14; a status read in the middle of the
      // pair resets the toggle, so the next address write is a high one again.
      send_word(MODE_WRITE, IDX_ADDR, 8'hFF, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_STATUS, 8'h00, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_ADDR, 8'h00, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_ADDR, 8'hAB, 3'd0, 8'h00);
      send_word(MODE_INCR, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      // Status flags and buffer at their extremes; the second read shows vblank
      // already cleared by the first.
      send_word(MODE_STATUS, IDX_CTRL, 8'h00, 3'd7, 8'hFF);
      send_word(MODE_READ, IDX_STATUS, 8'h00, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_STATUS, 8'h00, 3'd0, 8'h00);
      send_word(MODE_STATUS, IDX_CTRL, 8'h00, 3'd0, 8'h00);
      // A bus write to the status register stores the whole byte.
      send_word(MODE_WRITE, IDX_STATUS, 8'hFF, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_STATUS, 8'h00, 3'd0, 8'h00);
      // Plain storage and read-back of the registers with side effects.
      send_word(MODE_WRITE, IDX_SPARE_7, 8'hA5, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_SPARE_7, 8'h00, 3'd0, 8'h00);
      send_word(MODE_WRITE, IDX_SPARE_1, 8'h5A, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_SCROLL, 8'h00, 3'd0, 8'h00);
      send_word(MODE_READ, IDX_ADDR, 8'h00, 3'd0, 8'h00);
      // Unused modes change nothing but still answer.
      send_word(MODE_SPARE_A, IDX_ADDR, 8'hFF, 3'd7, 8'hFF);
      send_word(MODE_SPARE_B, IDX_SCROLL, 8'hFF, 3'd7, 8'hFF);
      wait_drained();

      // Random part in three idling phases: a slow receiver, a slow sender, and
      // then full rate on both sides. The sender drains between phases.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               take_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               take_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         for (n = 0; n < WORDS_PER_PHASE; n++) send_random_word();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
